// ===== rtl/run_length_line_table_core_defines.svh =====
// assertion macros for the run-length line table core
// used by rllt_ctrl and rllt_dpath, which provide clk_i and rst_ni
`ifndef RUN_LENGTH_LINE_TABLE_CORE_DEFINES_SVH
`define RUN_LENGTH_LINE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RLLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rllt assertion failed");

// next-cycle implication, checked out of reset
`define RLLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rllt assertion failed");

`endif

// ===== rtl/rllt_pkg.sv =====
// shared types and constants for the run-length line table core
// no dependencies
package rllt_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned LineW         = 16;
  localparam int unsigned EntryW        = LineW + 1;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncLookup = 1'b1;

  localparam logic [LineW-1:0] RunMax = {LineW{1'b1}};

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic walk;    // lookup walk in progress
    logic resp;    // load lookup result into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic walk_done;  // lookup walk has its answer
  } status_t;

endpackage

// ===== rtl/rllt_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module rllt_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rllt_ctrl.sv =====
// controller state machine of the run-length line table core
// depends on rllt_pkg and run_length_line_table_core_defines.svh
`include "run_length_line_table_core_defines.svh"

module rllt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_stall_o,
  input  rllt_pkg::status_t status_i,
  output rllt_pkg::cmd_t    cmd_o
);

  import rllt_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StResp = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign take = (state_q == StIdle) && in_valid_i && status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take && (func_i == FuncLookup)) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (status_i.walk_done) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o   = !((state_q == StIdle) && status_i.out_free);
  assign cmd_o.accept = take;
  assign cmd_o.walk   = (state_q == StWalk);
  assign cmd_o.resp   = (state_q == StResp) && status_i.out_free;

  `RLLT_ASSERT_IMP(a_busy_stalls, state_q != StIdle, in_stall_o)
  `RLLT_ASSERT_NXT(a_resp_to_idle, cmd_o.resp, state_q == StIdle)

endmodule

// ===== rtl/rllt_dpath.sv =====
// datapath of the run-length line table core: entry store, append logic,
// lookup walk and output register; depends on rllt_pkg, rllt_ram and the defines header
`include "run_length_line_table_core_defines.svh"

module rllt_dpath #(
  parameter int unsigned TABLE_DEPTH = rllt_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rllt_pkg::cmd_t             cmd_i,
  output rllt_pkg::status_t          status_o,
  input  logic                       func_i,
  input  logic [rllt_pkg::LineW-1:0] line_number_i,
  input  logic [rllt_pkg::LineW-1:0] instr_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rllt_pkg::LineW-1:0] line_out_o,
  output logic                       found_o,
  output logic                       dropped_o
);

  import rllt_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PosW  = CntW + LineW;

  // table bookkeeping, last two entries shadowed so appends need no read
  logic [CntW-1:0]   count_q, count_d;
  logic [EntryW-1:0] last_q, last_d, prev_q, prev_d;

  // lookup walk
  logic [CntW-1:0]   issue_q;
  logic              rd_vld_q;
  logic [PosW-1:0]   pos_q;
  logic [LineW-1:0]  cur_q, idx_q, res_line_q;
  logic              res_found_q;

  // output register
  logic              out_valid_q;
  logic [LineW-1:0]  line_out_q;
  logic              found_q, dropped_q;

  logic              append, cnt_nz, full, follows_line, run_inc, push, drop;
  logic [EntryW-1:0] new_entry;
  logic [CntW-1:0]   cnt_m1;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [EntryW-1:0] wdata;
  logic              re;
  logic [EntryW-1:0] rdata;
  logic              rd_run, hit;
  logic [LineW-1:0]  run_len, hit_line;
  logic [PosW-1:0]   pos_end;

  assign append       = cmd_i.accept && (func_i == FuncAppend);
  assign cnt_nz       = (count_q != '0);
  assign full         = (count_q == CntW'(TABLE_DEPTH));
  assign cnt_m1       = count_q - CntW'(1);
  // last entry is a run that follows a line entry with the same line
  assign follows_line = cnt_nz && last_q[LineW] && (prev_q == {1'b0, line_number_i});
  assign run_inc      = follows_line && (last_q[LineW-1:0] != RunMax);

  always_comb begin
    if (cnt_nz && !last_q[LineW] && (last_q[LineW-1:0] == line_number_i)) begin
      new_entry = {1'b1, LineW'(1)};
    end else begin
      new_entry = {1'b0, line_number_i};
    end
  end

  assign push  = append && !run_inc && !full;
  assign drop  = append && !run_inc && full;
  assign we    = (append && run_inc) || push;
  assign waddr = run_inc ? cnt_m1[AddrW-1:0] : count_q[AddrW-1:0];
  assign wdata = run_inc ? {1'b1, last_q[LineW-1:0] + LineW'(1)} : new_entry;

  always_comb begin
    count_d = count_q;
    last_d  = last_q;
    prev_d  = prev_q;
    if (append && run_inc) begin
      last_d = wdata;
    end else if (push) begin
      count_d = count_q + CntW'(1);
      last_d  = new_entry;
      prev_d  = last_q;
    end
  end

  rllt_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (issue_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // reads go out one per cycle, data comes back in the next cycle
  assign re       = cmd_i.walk && (issue_q != count_q);
  assign rd_run   = rdata[LineW];
  assign run_len  = rd_run ? rdata[LineW-1:0] : LineW'(1);
  assign pos_end  = pos_q + PosW'(run_len);
  assign hit      = cmd_i.walk && rd_vld_q && (PosW'(idx_q) < pos_end);
  assign hit_line = rd_run ? cur_q : rdata[LineW-1:0];

  assign status_o.walk_done = hit || (!rd_vld_q && (issue_q == count_q));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.accept) begin
        issue_q  <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.walk) begin
        issue_q  <= issue_q + CntW'(re);
        rd_vld_q <= re;
      end
      if (cmd_i.accept || cmd_i.resp) begin
        out_valid_q <= (append || cmd_i.resp);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    prev_q <= prev_d;
    if (cmd_i.accept) begin
      pos_q       <= '0;
      cur_q       <= '0;
      idx_q       <= instr_index_i;
      res_line_q  <= '0;
      res_found_q <= 1'b0;
    end else if (cmd_i.walk && rd_vld_q) begin
      pos_q <= pos_end;
      if (!rd_run) begin
        cur_q <= rdata[LineW-1:0];
      end
      if (hit) begin
        res_line_q  <= hit_line;
        res_found_q <= 1'b1;
      end
    end
    if (append) begin
      line_out_q <= '0;
      found_q    <= 1'b0;
      dropped_q  <= drop;
    end else if (cmd_i.resp) begin
      line_out_q <= res_line_q;
      found_q    <= res_found_q;
      dropped_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_out_o  = line_out_q;
  assign found_o     = found_q;
  assign dropped_o   = dropped_q;

  `RLLT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(TABLE_DEPTH))
  `RLLT_ASSERT_IMP(a_drop_only_full, drop, count_q == CntW'(TABLE_DEPTH))
  `RLLT_ASSERT_IMP(a_found_xor_drop, out_valid_q && dropped_q, !found_q && line_out_q == '0)

endmodule

// ===== rtl/run_length_line_table_core.sv =====
// run-length line table core: maps instruction positions to source lines
// two channels, valid/stall, one result per request; func 0 appends the line
// of the next instruction, func 1 looks up the line of instr_index.
// an append is taken and its result sits in the output register
// on the next cycle; with the output not stalled one append a cycle is taken.
// a lookup walks the stored entries through the single read port of the entry
// ram, one entry a cycle, and answers once it hits or has read every entry; no new
// request is taken during the walk.
// appends needing a new entry in a full table are flagged as dropped.
// reset empties the table at once (the entry count is cleared, no ram sweep)
// and clears the output valid flag. while the receiver stalls, the result holds
// and a new request is taken only in the cycle the waiting result is taken.
// depends on rllt_pkg, rllt_ctrl, rllt_dpath and rllt_ram
module run_length_line_table_core #(
  parameter int unsigned TABLE_DEPTH = rllt_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [rllt_pkg::LineW-1:0] line_number_i,
  input  logic [rllt_pkg::LineW-1:0] instr_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rllt_pkg::LineW-1:0] line_out_o,
  output logic                       found_o,
  output logic                       dropped_o
);

  import rllt_pkg::*;

  cmd_t    cmd;
  status_t status;

  rllt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rllt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .line_number_i (line_number_i),
    .instr_index_i (instr_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_out_o    (line_out_o),
    .found_o       (found_o),
    .dropped_o     (dropped_o)
  );

endmodule
